// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_INV(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, (expr), msg)

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_INV(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/olst_pkg.sv =====
package olst_pkg;

  localparam int unsigned CAPACITY_DEF = 8;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 4;

  localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ         = 3'd4;

  // slave tdata: position, value, zero pad to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  // master tdata: ok, entry_count, removed_count, read_data, zero pad
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic                     ok;
    logic [CNT_W-1:0]         entry_count;
    logic [CNT_W-1:0]         removed_count;
    logic signed [DATA_W-1:0] read_data;
  } res_t;

endpackage

// ===== rtl/core/olst_ram.sv =====
module olst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/olst_ctrl.sv =====
module olst_ctrl #(
  parameter int unsigned CAPACITY = olst_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [olst_pkg::KIND_W-1:0]        kind_i,
  input  logic [olst_pkg::POS_W-1:0]         pos_i,
  input  logic [olst_pkg::DATA_W-1:0]        value_i,
  input  logic                               cfg_valid_i,
  input  logic [olst_pkg::DATA_W-1:0]        cfg_data_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output olst_pkg::res_t                     res_o,
  output logic                               mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]        mem_waddr_o,
  output logic [olst_pkg::DATA_W-1:0]        mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]        mem_raddr_o,
  input  logic [olst_pkg::DATA_W-1:0]        mem_rdata_i
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [olst_pkg::KIND_W-1:0]      kind_q, kind_d;
  logic [olst_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [olst_pkg::DATA_W-1:0]      val_q, val_d;
  logic [olst_pkg::DATA_W-1:0]      fill_q;
  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    idx_q, idx_d;
  logic [CW-1:0]                    kept_q, kept_d;
  logic [CW-1:0]                    removed_q, removed_d;
  logic                             ok_q, ok_d;
  logic [olst_pkg::DATA_W-1:0]      rdata_q, rdata_d;

  logic          in_fire;
  logic          not_full;
  logic [KW-1:0] pos_k, cnt_k;
  logic [CW-1:0] idx_m1, idx_p1;
  logic          mismatch;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign not_full   = count_q < CW'(CAPACITY);
  assign pos_k      = KW'(pos_i);
  assign cnt_k      = KW'(count_q);
  assign idx_m1     = idx_q - CW'(1);
  assign idx_p1     = idx_q + CW'(1);
  assign mismatch   = mem_rdata_i != val_q;

  always_comb begin
    unique case (kind_q)
      olst_pkg::KIND_INSERT:    mem_raddr_o = AW'(idx_m1);
      olst_pkg::KIND_REMOVE_AT: mem_raddr_o = AW'(idx_p1);
      default:                  mem_raddr_o = AW'(idx_q);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    removed_d   = removed_q;
    ok_d        = ok_q;
    rdata_d     = rdata_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(idx_q);
    mem_wdata_o = mem_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d    = kind_i;
          pos_d     = pos_i;
          val_d     = value_i;
          ok_d      = 1'b0;
          removed_d = '0;
          rdata_d   = '0;
          kept_d    = '0;
          state_d   = ST_RESP;
          unique case (kind_i)
            olst_pkg::KIND_APPEND: begin
              if (not_full) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(count_q);
                mem_wdata_o = value_i;
                count_d     = count_q + CW'(1);
                ok_d        = 1'b1;
              end
            end
            olst_pkg::KIND_INSERT: begin
              if (not_full && pos_k <= cnt_k) begin
                ok_d    = 1'b1;
                idx_d   = count_q;
                state_d = (cnt_k > pos_k) ? ST_RD : ST_LAST;
              end
            end
            olst_pkg::KIND_REMOVE_AT: begin
              if (pos_k < cnt_k) begin
                ok_d      = 1'b1;
                removed_d = CW'(1);
                idx_d     = CW'(pos_i);
                if (pos_k + KW'(1) < cnt_k) begin
                  state_d = ST_RD;
                end else begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            olst_pkg::KIND_REMOVE_VALUE: begin
              ok_d  = 1'b1;
              idx_d = '0;
              if (count_q != '0) begin
                state_d = ST_RD;
              end
            end
            olst_pkg::KIND_READ: begin
              if (pos_k < cnt_k) begin
                ok_d    = 1'b1;
                idx_d   = CW'(pos_i);
                state_d = ST_RD;
              end else begin
                rdata_d = fill_q;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RD: state_d = ST_WR;

      ST_WR: begin
        unique case (kind_q)
          olst_pkg::KIND_INSERT: begin
            // entry below moves up one slot
            mem_we_o = 1'b1;
            idx_d    = idx_m1;
            state_d  = (KW'(idx_m1) > KW'(pos_q)) ? ST_RD : ST_LAST;
          end
          olst_pkg::KIND_REMOVE_AT: begin
            mem_we_o = 1'b1;
            idx_d    = idx_p1;
            if ((idx_p1 + CW'(1)) < count_q) begin
              state_d = ST_RD;
            end else begin
              count_d = count_q - CW'(1);
              state_d = ST_RESP;
            end
          end
          olst_pkg::KIND_REMOVE_VALUE: begin
            // compaction: survivors land at the kept index, never ahead of the scan
            mem_we_o    = mismatch;
            mem_waddr_o = AW'(kept_q);
            kept_d      = kept_q + CW'(mismatch);
            idx_d       = idx_p1;
            if (idx_p1 < count_q) begin
              state_d = ST_RD;
            end else begin
              count_d   = kept_d;
              removed_d = count_q - kept_d;
              state_d   = ST_RESP;
            end
          end
          default: begin
            rdata_d = mem_rdata_i;
            state_d = ST_RESP;
          end
        endcase
      end

      ST_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(pos_q);
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i) begin
        fill_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    kept_q    <= kept_d;
    removed_q <= removed_d;
    ok_q      <= ok_d;
    rdata_q   <= rdata_d;
  end

  assign res_valid_o         = (state_q == ST_RESP);
  assign res_o.ok            = ok_q;
  assign res_o.entry_count   = olst_pkg::CNT_W'(count_q);
  assign res_o.removed_count = olst_pkg::CNT_W'(removed_q);
  assign res_o.read_data     = rdata_q;

  `ASSERT_INV(a_count_in_range, clk_i, rst_ni, count_q <= CW'(CAPACITY),
    "live count exceeds capacity")
  `ASSERT_PROP(a_rd_then_wr, clk_i, rst_ni, (state_q == ST_RD) |=> (state_q == ST_WR),
    "memory read not followed by its write-back step")
  `ASSERT_PROP(a_kept_behind_scan, clk_i, rst_ni,
    (state_q == ST_WR && kind_q == olst_pkg::KIND_REMOVE_VALUE) |-> (kept_q <= idx_q),
    "compaction write index passed the scan index")
  `ASSERT_PROP(a_accept_leaves_idle, clk_i, rst_ni, in_fire |=> (state_q != ST_IDLE),
    "accepted item did not start an operation")

endmodule

// ===== rtl/core/ordered_array_list_store_core.sv =====
// Ordered list of up to CAPACITY signed 32-bit words held in one single-port-write,
// registered-read RAM, with the live count in a register. One item is in work at a
// time and gives one result. Append, rejected and unused kinds need no RAM read;
// read takes one; insert shifts entries from the position up, then writes the
// value; remove at position shifts later entries down; remove value scans all live
// entries. Each moved or scanned entry takes a RAM read and a write-back step, as
// the RAM read is registered. A result waits in the output register while the next
// item is accepted. Slots above the count are never read back, so no clearing pass
// runs after reset; reads beyond the count return the current fill value.
module ordered_array_list_store_core #(
  parameter int unsigned CAPACITY = olst_pkg::CAPACITY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position[2:0], value[34:3], zero pad
  input  logic [olst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind[2:0]
  input  logic [olst_pkg::KIND_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // ok[0], entry_count[4:1], removed_count[8:5], read_data[40:9], zero pad
  output logic [olst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [olst_pkg::DATA_W-1:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned RES_W = $bits(olst_pkg::res_t);

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [olst_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;
  logic                          res_valid, res_ready;
  olst_pkg::res_t                res;
  olst_pkg::res_t                out_q;
  logic                          out_valid_q;

  assign cfg_ready_o = 1'b1;

  olst_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .pos_i      (s_axis_tdata[olst_pkg::POS_W-1:0]),
    .value_i    (s_axis_tdata[olst_pkg::POS_W +: olst_pkg::DATA_W]),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  olst_ram #(
    .WIDTH(olst_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register decouples the result from the next item
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(olst_pkg::OUT_TDATA_W - RES_W){1'b0}},
                          out_q.read_data, out_q.removed_count,
                          out_q.entry_count, out_q.ok};

endmodule

// ===== tb/ordered_array_list_store_core_test.sv =====
`timescale 1ns / 1ps

// keeps a copy of the ordered list and queues one expected result per accepted item
class list_scoreboard;

  logic signed [olst_pkg::DATA_W-1:0] slots [olst_pkg::CAPACITY_DEF];
  int unsigned live;
  logic signed [olst_pkg::DATA_W-1:0] fill;
  olst_pkg::res_t awaited [$];
  int unsigned mismatches;
  int unsigned results_seen;

  function void reset_state();
    foreach (slots[i]) slots[i] = '0;
    live = 0;
    fill = '0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void set_fill(logic signed [olst_pkg::DATA_W-1:0] v);
    fill = v;
  endfunction

  function void refill_tail();
    for (int unsigned i = live; i < olst_pkg::CAPACITY_DEF; i++) slots[i] = fill;
  endfunction

  function olst_pkg::res_t predict_op(logic [olst_pkg::KIND_W-1:0] kind,
                                      logic [olst_pkg::POS_W-1:0] pos,
                                      logic signed [olst_pkg::DATA_W-1:0] val);
    olst_pkg::res_t r;
    int unsigned kept;
    r = '0;
    case (kind)
      olst_pkg::KIND_APPEND: begin
        if (live < olst_pkg::CAPACITY_DEF) begin
          slots[live] = val;
          live++;
          r.ok = 1'b1;
        end
      end
      olst_pkg::KIND_INSERT: begin
        if (live < olst_pkg::CAPACITY_DEF && pos <= live) begin
          for (int unsigned i = live; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = val;
          live++;
          r.ok = 1'b1;
        end
      end
      olst_pkg::KIND_REMOVE_AT: begin
        if (pos < live) begin
          for (int unsigned i = pos; i + 1 < live; i++) slots[i] = slots[i+1];
          live--;
          refill_tail();
          r.removed_count = olst_pkg::CNT_W'(1);
          r.ok = 1'b1;
        end
      end
      olst_pkg::KIND_REMOVE_VALUE: begin
        kept = 0;
        // only live entries take part in the compare
        for (int unsigned i = 0; i < live; i++) begin
          if (slots[i] != val) begin
            slots[kept] = slots[i];
            kept++;
          end
        end
        r.removed_count = olst_pkg::CNT_W'(live - kept);
        live = kept;
        refill_tail();
        r.ok = 1'b1;
      end
      olst_pkg::KIND_READ: begin
        if (pos < live) begin
          r.read_data = slots[pos];
          r.ok = 1'b1;
        end else begin
          r.read_data = fill;
        end
      end
      default: ;
    endcase
    r.entry_count = olst_pkg::CNT_W'(live);
    return r;
  endfunction

  function void note_item(logic [olst_pkg::KIND_W-1:0] kind, logic [olst_pkg::POS_W-1:0] pos,
                          logic signed [olst_pkg::DATA_W-1:0] val);
    awaited.push_back(predict_op(kind, pos, val));
  endfunction

  function void compare_field(string name, logic [olst_pkg::DATA_W-1:0] exp_v,
                              logic [olst_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(logic [olst_pkg::OUT_TDATA_W-1:0] tdata);
    olst_pkg::res_t exp_r;
    results_seen++;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t ns: result with nothing expected, expected none, actual %0h", $time, tdata);
      return;
    end
    exp_r = awaited.pop_front();
    compare_field("ok", olst_pkg::DATA_W'(exp_r.ok), olst_pkg::DATA_W'(tdata[0]));
    compare_field("entry_count", olst_pkg::DATA_W'(exp_r.entry_count),
                  olst_pkg::DATA_W'(tdata[4:1]));
    compare_field("removed_count", olst_pkg::DATA_W'(exp_r.removed_count),
                  olst_pkg::DATA_W'(tdata[8:5]));
    compare_field("read_data", exp_r.read_data, tdata[40:9]);
  endfunction
endclass

module ordered_array_list_store_core_test;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 305;
  localparam int unsigned RANDOM_PHASES = 5;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [olst_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic [olst_pkg::KIND_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [olst_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [olst_pkg::DATA_W-1:0] cfg_data_i;

  list_scoreboard sb;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned items_sent;
  int unsigned fills_written;
  int unsigned idle_cycles;

  ordered_array_list_store_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: tready drops in random bursts
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [olst_pkg::KIND_W-1:0] kind, logic [olst_pkg::POS_W-1:0] pos,
                           logic signed [olst_pkg::DATA_W-1:0] val);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= olst_pkg::IN_TDATA_W'({val, pos});
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, pos, val);
    items_sent++;
  endtask

  // holds the sender off until every expected result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_fill(logic [olst_pkg::DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_fill(v);
    fills_written++;
  endtask

  function automatic logic [olst_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return 32'h5;
      5: return 32'h4;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned counted;
    int unsigned grow_pct;
    int unsigned r;
    logic [olst_pkg::KIND_W-1:0] kind;
    logic [olst_pkg::POS_W-1:0] pos;
    logic [olst_pkg::DATA_W-1:0] val;
    counted = 0;
    while (counted < n) begin
      grow_pct = (sb.live < 4) ? 60 : 35;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3)
        kind = olst_pkg::KIND_READ + olst_pkg::KIND_W'($urandom_range(1, 3));
      else if (r < grow_pct / 2) kind = olst_pkg::KIND_APPEND;
      else if (r < grow_pct) kind = olst_pkg::KIND_INSERT;
      else if (r < grow_pct + 15) kind = olst_pkg::KIND_REMOVE_AT;
      else if (r < grow_pct + 30) kind = olst_pkg::KIND_REMOVE_VALUE;
      else kind = olst_pkg::KIND_READ;
      if ($urandom_range(0, 4) != 0)
        pos = olst_pkg::POS_W'($urandom_range(0, sb.live > 7 ? 7 : sb.live));
      else pos = olst_pkg::POS_W'($urandom_range(0, 7));
      // mostly aim remove-value at something that is stored
      if (kind == olst_pkg::KIND_REMOVE_VALUE && sb.live != 0 && $urandom_range(0, 9) < 7)
        val = sb.slots[$urandom_range(0, sb.live - 1)];
      else
        val = pick_value();
      send_item(kind, pos, val);
      if (kind <= olst_pkg::KIND_READ) counted++;
    end
  endtask

  initial begin
    logic [olst_pkg::DATA_W-1:0] phase_fill;
    sb = new;
    sb.reset_state();
    items_sent = 0;
    fills_written = 0;
    tx_gap_pct = 10;
    rx_stall_pct = 10;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_fill(32'h8000_0000);
    send_item(olst_pkg::KIND_READ, 3'd0, 32'h1);
    send_item(olst_pkg::KIND_READ, 3'd7, 32'h1);
    send_item(olst_pkg::KIND_REMOVE_AT, 3'd0, 32'h0);
    send_item(olst_pkg::KIND_REMOVE_VALUE, 3'd0, 32'h0);
    send_item(olst_pkg::KIND_INSERT, 3'd1, 32'h11);          // past the count
    send_item(olst_pkg::KIND_INSERT, 3'd0, 32'h7fff_ffff);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h8000_0000);
    send_item(olst_pkg::KIND_INSERT, 3'd2, 32'hffff_ffff);   // position equal to count
    send_item(olst_pkg::KIND_INSERT, 3'd1, 32'h0);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h8000_0000);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h5);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h8000_0000);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h4);
    send_item(olst_pkg::KIND_APPEND, 3'd0, 32'h1);           // full
    send_item(olst_pkg::KIND_INSERT, 3'd3, 32'h2);           // full
    send_item(olst_pkg::KIND_READ, 3'd7, 32'h0);
    send_item(olst_pkg::KIND_READ + 3'd1, 3'd7, 32'hffff_ffff);
    send_item(olst_pkg::KIND_READ + 3'd2, 3'd0, 32'h0);
    send_item(olst_pkg::KIND_READ + 3'd3, 3'd5, 32'h8000_0000);
    send_item(olst_pkg::KIND_REMOVE_VALUE, 3'd0, 32'h8000_0000);
    send_item(olst_pkg::KIND_READ, 3'd6, 32'h0);             // freed slot
    send_item(olst_pkg::KIND_REMOVE_AT, 3'd4, 32'h0);
    send_item(olst_pkg::KIND_REMOVE_AT, 3'd4, 32'h0);        // equal to count
    send_item(olst_pkg::KIND_REMOVE_AT, 3'd0, 32'h0);
    send_item(olst_pkg::KIND_REMOVE_VALUE, 3'd0, 32'h1234_5678);
    drain();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p)
        1: phase_fill = 32'h7fff_ffff;
        2: phase_fill = 32'h0;
        3: phase_fill = 32'hffff_ffff;
        default: phase_fill = $urandom;
      endcase
      write_fill(phase_fill);
      if (p == RANDOM_PHASES) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 8;
          default: tx_gap_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 8;
          default: rx_stall_pct = 25;
        endcase
      end
      random_items(ITEMS_PER_PHASE);
      drain();
    end

    repeat (30) @(posedge clk_i);
    $display("covered %0d items (all kinds, full and empty list, rejects) under %0d fill values",
             items_sent, fills_written);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
